>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; the include guard keeps a second include harmless
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define CCR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ccr assertion failed");

// clocked check, also active during reset
`define CCR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ccr assertion failed");

`endif

>>> rtl/core/ccr_pkg.sv
// shared types, constants and the crc step of the console command recognizer
// no dependencies
package ccr_pkg;

  // register map
  localparam int unsigned CODE_COUNT = 8;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned HASH_W     = 16;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;

  // console characters
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // crc-16/modbus
  localparam logic [HASH_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [HASH_W-1:0] CRC_POLY = 16'hA001;

  typedef enum logic {
    LS_IDLE,
    LS_OPEN
  } line_state_e;

  typedef logic [CODE_COUNT-1:0][HASH_W-1:0] code_table_t;

  // end of line request from the line tracker
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
    logic [LEN_W-1:0]  kept_len;
  } line_evt_t;

  // one byte of reflected crc update
  function automatic logic [HASH_W-1:0] crc16_byte(logic [HASH_W-1:0] h_in,
                                                  logic [7:0] b);
    logic [HASH_W-1:0] h;
    h = h_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (h[0]) begin
        h = (h >> 1) ^ CRC_POLY;
      end else begin
        h = h >> 1;
      end
    end
    return h;
  endfunction

endpackage

>>> rtl/core/ccr_if.sv
// valid/ready channel interfaces for console bytes and recognizer results
// no dependencies
interface ccr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

interface ccr_res_if;
  logic        valid;
  logic        ready;
  logic        command_found;
  logic [2:0]  command_slot;
  logic [15:0] word_hash;
  logic [5:0]  kept_length;

  modport source (output valid, output command_found, output command_slot,
                  output word_hash, output kept_length, input ready);
  modport sink (input valid, input command_found, input command_slot,
                input word_hash, input kept_length, output ready);
endinterface

>>> rtl/core/console_command_recognizer_unit.sv
// top level of the console command recognizer: registers, line tracker, match
// depends on ccr_pkg, ccr_if, ccr_cfg_regs, ccr_line_fsm, ccr_cmd_match, assert_macros.svh
//
//  channel | direction | payload                                        | handshake
//  rx      | in        | rx_char                                        | valid/ready
//  res     | out       | command_found, command_slot, word_hash, length | valid/ready
//  apb     | in        | command_code_0..7 at paddr 4*i                 | psel/penable
//
// one byte per cycle while rx is not stalled: a byte is held in the input register,
// and the line state and crc update and the table compare run as it drains; a
// carriage return loads the result register at the edge on which it drains.
// reset clears the line state, the table and both valid flags at once.
// the input register drains into the line logic only while the result
// register is empty or being taken, so a stalled result stalls rx one deep.
`include "assert_macros.svh"

module console_command_recognizer_unit #(
  parameter int unsigned LINE_CAPACITY = 64,
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ccr_rx_if.sink                     rx,
  ccr_res_if.source                  res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccr_pkg::ADDR_W-1:0] paddr,
  input  logic [ccr_pkg::DATA_W-1:0] pwdata,
  output logic [ccr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ccr_pkg::*;

  code_table_t       codes;
  line_evt_t         evt;
  logic              adv_ok;
  logic              found;
  logic [SLOT_W-1:0] slot;

  logic              res_valid_q;
  logic              found_q;
  logic [SLOT_W-1:0] slot_q;
  logic [HASH_W-1:0] hash_q;
  logic [LEN_W-1:0]  len_q;

  // configuration registers
  ccr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .codes_o (codes)
  );

  assign adv_ok = ~res_valid_q | res.ready;

  // input stage and line tracking
  ccr_line_fsm #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_line (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx.valid),
    .in_char_i  (rx.rx_char),
    .in_ready_o (rx.ready),
    .adv_ok_i   (adv_ok),
    .evt_o      (evt)
  );

  // table lookup
  ccr_cmd_match #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_match (
    .codes_i (codes),
    .hash_i  (evt.hash),
    .found_o (found),
    .slot_o  (slot)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (evt.valid) begin
      res_valid_q <= 1'b1;
    end else if (res.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt.valid) begin
      found_q <= found;
      slot_q  <= slot;
      hash_q  <= evt.hash;
      len_q   <= evt.kept_len;
    end
  end

  assign res.valid         = res_valid_q;
  assign res.command_found = found_q;
  assign res.command_slot  = slot_q;
  assign res.word_hash     = hash_q;
  assign res.kept_length   = len_q;

  // checks
  `CCR_ASSERT(a_no_overwrite, clk_i, rst_ni, evt.valid |-> (!res_valid_q || res.ready))
  `CCR_ASSERT(a_slot_zero, clk_i, rst_ni, (res.valid && !res.command_found) |-> (res.command_slot == '0))
  `CCR_ASSERT(a_zero_never_found, clk_i, rst_ni, (res.valid && res.command_found) |-> (res.word_hash != '0))
  `CCR_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !res.valid)

endmodule

>>> rtl/core/ccr_cfg_regs.sv
// apb-style register file holding the command code table
// depends on ccr_pkg
module ccr_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ccr_pkg::ADDR_W-1:0] paddr,
  input  logic [ccr_pkg::DATA_W-1:0] pwdata,
  output logic [ccr_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output ccr_pkg::code_table_t      codes_o
);
  import ccr_pkg::*;

  code_table_t       codes_q;
  logic [SLOT_W-1:0] reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  // table registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q <= '0;
    end else if (wr_en) begin
      codes_q[reg_idx] <= pwdata[HASH_W-1:0];
    end
  end

  // read back
  assign prdata  = {{(DATA_W-HASH_W){1'b0}}, codes_q[reg_idx]};
  assign codes_o = codes_q;

endmodule

>>> rtl/core/ccr_line_fsm.sv
// input stage and line state: counts kept characters, hashes the first word
// depends on ccr_pkg
module ccr_line_fsm #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [7:0]            in_char_i,
  output logic                  in_ready_o,
  input  logic                  adv_ok_i,
  output ccr_pkg::line_evt_t    evt_o
);
  import ccr_pkg::*;

  localparam int unsigned CW = $clog2(LINE_CAPACITY - 1);
  localparam logic [CW-1:0] KEEP_MAX = CW'(LINE_CAPACITY - 2);

  logic              stg_valid_q;
  logic [7:0]        stg_char_q;
  logic              fire;

  line_state_e       state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic              word_q, word_d;
  logic [CW+LEN_W-1:0] cnt_ext;
  logic [HASH_W-1:0] hash_step;
  logic              is_ign;

  assign fire       = stg_valid_q & adv_ok_i;
  assign in_ready_o = ~stg_valid_q | fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stg_char_q <= in_char_i;
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LS_IDLE;
      cnt_q   <= '0;
      hash_q  <= CRC_INIT;
      word_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hash_q  <= hash_d;
      word_q  <= word_d;
    end
  end

  assign is_ign  = (stg_char_q == CH_ESC) || (stg_char_q == CH_TAB) ||
                   (stg_char_q == CH_BS) || (stg_char_q == CH_LF);
  assign cnt_ext = {{LEN_W{1'b0}}, cnt_q};

  // next state and end of line request
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    hash_d    = hash_q;
    word_d    = word_q;
    hash_step = crc16_byte((state_q == LS_IDLE) ? CRC_INIT : hash_q, stg_char_q);
    evt_o.valid    = 1'b0;
    evt_o.hash     = hash_q;
    evt_o.kept_len = cnt_ext[LEN_W-1:0];
    if (fire) begin
      case (state_q)
        LS_IDLE: begin
          if (!is_ign && stg_char_q != CH_SPACE && stg_char_q != CH_CR) begin
            state_d = LS_OPEN;
            cnt_d   = CW'(1);
            hash_d  = hash_step;
            word_d  = 1'b1;
          end
        end
        LS_OPEN: begin
          if (stg_char_q == CH_CR) begin
            evt_o.valid = 1'b1;
            state_d     = LS_IDLE;
            cnt_d       = '0;
            hash_d      = CRC_INIT;
            word_d      = 1'b0;
          end else if (!is_ign && cnt_q < KEEP_MAX) begin
            cnt_d = cnt_q + CW'(1);
            if (word_q) begin
              if (stg_char_q == CH_SPACE) begin
                word_d = 1'b0;
              end else begin
                hash_d = hash_step;
              end
            end
          end
        end
        default: begin
          state_d = LS_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/ccr_cmd_match.sv
// ordered search of the command table, stops at the first zero entry
// depends on ccr_pkg
module ccr_cmd_match #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  ccr_pkg::code_table_t      codes_i,
  input  logic [ccr_pkg::HASH_W-1:0] hash_i,
  output logic                      found_o,
  output logic [ccr_pkg::SLOT_W-1:0] slot_o
);
  import ccr_pkg::*;

  logic stop;

  // priority walk over the searched entries
  always_comb begin
    stop    = 1'b0;
    found_o = 1'b0;
    slot_o  = '0;
    for (int k = 0; k < CODE_COUNT; k++) begin
      if (k < TABLE_ENTRIES && !stop) begin
        if (codes_i[k] == '0) begin
          stop = 1'b1;
        end else if (codes_i[k] == hash_i) begin
          stop    = 1'b1;
          found_o = 1'b1;
          slot_o  = SLOT_W'(k);
        end
      end
    end
  end

endmodule
